[hdl/gfti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and codes for the trilinear field-map interpolator.
// Used by gfti_axis, gfti_bank and the top level; depends on nothing.
package gfti_pkg;

  localparam int ADDR_W   = 15;   // node table address width
  localparam int POS_W    = 32;   // Q11.20 positions and origins
  localparam int CFG_W    = 32;   // widest configuration register
  localparam int CFG_AW   = 3;    // configuration register index width
  localparam int FRAC_W   = 36;   // fraction bits of position * inv_spacing
  localparam int OUT_W    = 32;   // width of each result component
  localparam int NCOMP    = 6;    // Ex, Ey, Ez, Bx, By, Bz
  localparam int IN_DATA_W  = 304;
  localparam int OUT_DATA_W = 192;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_X    = 3'd3,
    CFG_INV_Y    = 3'd4,
    CFG_INV_Z    = 3'd5
  } cfg_idx_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] INV_RESET = 32'd65536;

endpackage
`default_nettype wire

[hdl/gfti_axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// One axis of the cell lookup: offset, scale, range check, index and lever.
// Three register stages; depends on gfti_pkg.
module gfti_axis #(
  parameter int GRID       = 32,
  parameter int LEVER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [gfti_pkg::POS_W-1:0] pos,
  input  wire logic signed [gfti_pkg::POS_W-1:0] org,
  input  wire logic        [gfti_pkg::POS_W-1:0] inv,
  output logic             [$clog2(GRID)-1:0]   idx,
  output logic             [LEVER_BITS-1:0]     lev,
  output logic                                  ok
);
  import gfti_pkg::*;

  localparam int IW = $clog2(GRID);
  localparam int HI_W = 2 * POS_W - FRAC_W;

  logic signed [POS_W:0]   diff;
  logic        [POS_W-1:0] mag;
  logic                    neg1;
  logic [2*POS_W-1:0]      prod;
  logic                    neg2;

  assign diff = {pos[POS_W-1], pos} - {org[POS_W-1], org};

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= diff[POS_W];
      mag  <= diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
      prod <= {{POS_W{1'b0}}, mag} * {{POS_W{1'b0}}, inv};
      neg2 <= neg1;
      // A negative offset is only allowed when it scales to exactly zero.
      ok   <= !(neg2 && (prod != '0)) &&
              (prod[2*POS_W-1:FRAC_W] <= HI_W'(GRID - 2));
      idx  <= prod[FRAC_W +: IW];
      lev  <= prod[FRAC_W-1 -: LEVER_BITS];
    end
  end

endmodule
`default_nettype wire

[hdl/gfti_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// Node table copy: one write port and two registered read ports.
// Depends on gfti_pkg for the address width.
module gfti_bank #(
  parameter int DW = 192
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [gfti_pkg::ADDR_W-1:0] waddr,
  input  wire logic [DW-1:0]               wdata,
  input  wire logic                        re,
  input  wire logic [gfti_pkg::ADDR_W-1:0] raddr0,
  input  wire logic [gfti_pkg::ADDR_W-1:0] raddr1,
  output logic      [DW-1:0]               rdata0,
  output logic      [DW-1:0]               rdata1
);
  import gfti_pkg::*;

  logic [DW-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

[hdl/gfti_lerp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-stage linear blend round((a*(S-l) + b*l) / S), ties toward plus infinity.
// Depends on nothing but its parameters.
module gfti_lerp #(
  parameter int W          = 32,
  parameter int LEVER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  input  wire logic [LEVER_BITS-1:0] l,
  output logic signed [W-1:0]        r
);

  localparam int PW = W + LEVER_BITS + 2;
  localparam logic [LEVER_BITS:0] SCALE = {1'b1, {LEVER_BITS{1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(SCALE >> 1);

  logic signed [LEVER_BITS+1:0] wa;
  logic signed [LEVER_BITS+1:0] wb;
  logic signed [PW-1:0]         pa;
  logic signed [PW-1:0]         pb;
  logic signed [PW-1:0]         sum;

  assign wa  = $signed({1'b0, SCALE - {1'b0, l}});
  assign wb  = $signed({2'b00, l});
  assign sum = pa + pb + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= PW'(a * wa);
      pb <= PW'(b * wb);
      // The blend stays between a and b, so the low W bits above the
      // fraction are the whole result.
      r  <= sum[LEVER_BITS +: W];
    end
  end

endmodule
`default_nettype wire

[hdl/grid_field_trilinear_interp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Trilinear field-map interpolator, top level.
// Input words (s_*): s_tuser is func; a load word writes one node of the six
// component tables, a query word carries a position. Each query gives one
// output word (m_*): in_range in m_tuser and six blended components in
// m_tdata, all zero when the cell leaves the grid. Loads give no word.
// Configuration: the user must write origins and reciprocal spacings through
// cfg_we/cfg_addr/cfg_data only while the block is idle; it is not enforced.
// Throughput is one word per cycle while the output is not stalled. A query
// passes through offset and scale, cell address and corner offsets, the table
// read and the three blend levels before its result shows on m_tvalid.
// The rate is set by the table: four copies with two read ports each serve
// the eight corners of a cell at once. A load updates the table on the same
// stage where queries read, so a query always sees every load accepted before
// it. Reset clears the valid bits and the origins and sets each reciprocal
// spacing to INV_RESET; table contents stay undefined until loaded. When
// m_tready is low while m_tvalid is high the whole pipeline holds and s_tready
// drops with it; nothing is lost or repeated.
module grid_field_trilinear_interp #(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int FIELD_BITS = 32,
  parameter int LEVER_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // node_addr, load_ex, load_ey, load_ez, load_bx, load_by, load_bz,
  // pos_x, pos_y, pos_z, then one pad bit
  input  wire logic [gfti_pkg::IN_DATA_W-1:0]     s_tdata,
  // func
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // out_ex, out_ey, out_ez, out_bx, out_by, out_bz
  output logic [gfti_pkg::OUT_DATA_W-1:0]         m_tdata,
  // in_range
  output logic                                    m_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [gfti_pkg::CFG_AW-1:0]        cfg_addr,
  input  wire logic [gfti_pkg::CFG_W-1:0]         cfg_data
);
  import gfti_pkg::*;

  localparam int SW = (FIELD_BITS < 32) ? FIELD_BITS : 32;
  localparam int DW = NCOMP * SW;
  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int ZW = $clog2(GRID_Z);
  localparam logic [ADDR_W-1:0] GX  = ADDR_W'(GRID_X);
  localparam logic [ADDR_W-1:0] GY  = ADDR_W'(GRID_Y);
  localparam logic [ADDR_W-1:0] GXY = ADDR_W'(GRID_X * GRID_Y);
  localparam int POSX_LSB = ADDR_W + NCOMP * 32;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Configuration registers.
  logic signed [POS_W-1:0] origin_x, origin_y, origin_z;
  logic        [POS_W-1:0] inv_x, inv_y, inv_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      inv_x    <= INV_RESET;
      inv_y    <= INV_RESET;
      inv_z    <= INV_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        CFG_ORIGIN_Z: origin_z <= cfg_data;
        CFG_INV_X:    inv_x    <= cfg_data;
        CFG_INV_Y:    inv_y    <= cfg_data;
        CFG_INV_Z:    inv_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load words keep the low SW bits of each component.
  logic [DW-1:0] load_word;
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      load_word[c*SW +: SW] = s_tdata[ADDR_W + c*32 +: SW];
    end
  end

  // Axis units, stages 1 to 3.
  logic [XW-1:0] ix3;
  logic [YW-1:0] iy3;
  logic [ZW-1:0] iz3;
  logic [LEVER_BITS-1:0] lx3, ly3, lz3;
  logic okx3, oky3, okz3;

  gfti_axis #(.GRID(GRID_X), .LEVER_BITS(LEVER_BITS)) u_axis_x (
    .clk(clk), .en(adv), .pos(s_tdata[POSX_LSB +: POS_W]), .org(origin_x),
    .inv(inv_x), .idx(ix3), .lev(lx3), .ok(okx3)
  );
  gfti_axis #(.GRID(GRID_Y), .LEVER_BITS(LEVER_BITS)) u_axis_y (
    .clk(clk), .en(adv), .pos(s_tdata[POSX_LSB + POS_W +: POS_W]), .org(origin_y),
    .inv(inv_y), .idx(iy3), .lev(ly3), .ok(oky3)
  );
  gfti_axis #(.GRID(GRID_Z), .LEVER_BITS(LEVER_BITS)) u_axis_z (
    .clk(clk), .en(adv), .pos(s_tdata[POSX_LSB + 2*POS_W +: POS_W]), .org(origin_z),
    .inv(inv_z), .idx(iz3), .lev(lz3), .ok(okz3)
  );

  // Word control and load payload through stages 1 to 6.
  logic [6:1] vq;
  logic [6:1] vl;
  logic [ADDR_W-1:0] waddr [6:1];
  logic [DW-1:0]     wdata [6:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
      vl <= '0;
    end else if (adv) begin
      vq <= {vq[5:1], s_tvalid && (s_tuser == FUNC_QUERY)};
      vl <= {vl[5:1], s_tvalid && (s_tuser == FUNC_LOAD)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      waddr[1] <= s_tdata[ADDR_W-1:0];
      wdata[1] <= load_word;
      for (int s = 2; s <= 6; s++) begin
        waddr[s] <= waddr[s-1];
        wdata[s] <= wdata[s-1];
      end
    end
  end

  // Stages 4 to 6: cell address and the eight corner addresses.
  logic [ADDR_W-1:0] ix4, t4, base5;
  logic [ADDR_W-1:0] off6 [8];
  logic ok4, ok5, ok6;
  logic [LEVER_BITS-1:0] lx4, ly4, lz4, lx5, ly5, lz5, lx6, ly6, lz6;

  always_ff @(posedge clk) begin
    if (adv) begin
      ix4  <= ADDR_W'(ix3);
      t4   <= ADDR_W'(iy3) + ADDR_W'(ADDR_W'(iz3) * GY);
      ok4  <= okx3 && oky3 && okz3;
      lx4  <= lx3;
      ly4  <= ly3;
      lz4  <= lz3;
      base5 <= ix4 + ADDR_W'(t4 * GX);
      ok5  <= ok4;
      lx5  <= lx4;
      ly5  <= ly4;
      lz5  <= lz4;
      for (int k = 0; k < 8; k++) begin
        off6[k] <= base5 + (k[0] ? ADDR_W'(1) : '0) + (k[1] ? GX : '0)
                 + (k[2] ? GXY : '0);
      end
      ok6  <= ok5;
      lx6  <= lx5;
      ly6  <= ly5;
      lz6  <= lz5;
    end
  end

  // Stage 7: table read. Every copy takes every load.
  logic [DW-1:0] corner [8];

  for (genvar j = 0; j < 4; j++) begin : g_bank
    gfti_bank #(.DW(DW)) u_bank (
      .clk(clk), .we(adv && vl[6]), .waddr(waddr[6]), .wdata(wdata[6]),
      .re(adv), .raddr0(off6[2*j]), .raddr1(off6[2*j+1]),
      .rdata0(corner[2*j]), .rdata1(corner[2*j+1])
    );
  end

  // Control through stages 7 to 13.
  logic [13:7] vq_t;
  logic [13:7] ok_t;
  logic [LEVER_BITS-1:0] lx7, ly7, ly8, ly9, lz7, lz8, lz9, lz10, lz11;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq_t <= '0;
    end else if (adv) begin
      vq_t <= {vq_t[12:7], vq[6]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_t <= {ok_t[12:7], ok6};
      lx7  <= lx6;
      ly7  <= ly6;
      ly8  <= ly7;
      ly9  <= ly8;
      lz7  <= lz6;
      lz8  <= lz7;
      lz9  <= lz8;
      lz10 <= lz9;
      lz11 <= lz10;
    end
  end

  // Blend tree per component: x, then y, then z.
  logic signed [SW-1:0] xr [NCOMP][4];
  logic signed [SW-1:0] yr [NCOMP][2];
  logic signed [SW-1:0] zr [NCOMP];

  for (genvar c = 0; c < NCOMP; c++) begin : g_comp
    for (genvar p = 0; p < 4; p++) begin : g_x
      gfti_lerp #(.W(SW), .LEVER_BITS(LEVER_BITS)) u_lx (
        .clk(clk), .en(adv), .a(corner[2*p][c*SW +: SW]),
        .b(corner[2*p+1][c*SW +: SW]), .l(lx7), .r(xr[c][p])
      );
    end
    for (genvar p = 0; p < 2; p++) begin : g_y
      gfti_lerp #(.W(SW), .LEVER_BITS(LEVER_BITS)) u_ly (
        .clk(clk), .en(adv), .a(xr[c][2*p]), .b(xr[c][2*p+1]),
        .l(ly9), .r(yr[c][p])
      );
    end
    gfti_lerp #(.W(SW), .LEVER_BITS(LEVER_BITS)) u_lz (
      .clk(clk), .en(adv), .a(yr[c][0]), .b(yr[c][1]), .l(lz11), .r(zr[c])
    );
    assign m_tdata[c*OUT_W +: OUT_W] = ok_t[13] ? OUT_W'(zr[c]) : '0;
  end

  assign m_tvalid = vq_t[13];
  assign m_tuser  = ok_t[13];

endmodule
`default_nettype wire
